// ===== hw/rtl/char_lcd_nibble_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_defines
// assertion macros for the lcd sequencer controller
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCDNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LCDNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lcdns_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdns_pkg
// shared codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // request operations
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_CHAR   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE_HIGH = 3'd0;
  localparam logic [2:0] REG_SETTLE      = 3'd1;
  localparam logic [2:0] REG_WAKE_HIGH   = 3'd2;
  localparam logic [2:0] REG_WAKE_SETTLE = 3'd3;
  localparam logic [2:0] REG_POWER_UP    = 3'd4;
  localparam logic [2:0] REG_CLEAR_EXTRA = 3'd5;

  // reset values of the timing registers
  localparam logic [15:0] RST_ENABLE_HIGH = 16'd10;
  localparam logic [15:0] RST_SETTLE      = 16'd50000;
  localparam logic [15:0] RST_WAKE_HIGH   = 16'd250;
  localparam logic [15:0] RST_WAKE_SETTLE = 16'd30000;
  localparam logic [15:0] RST_POWER_UP    = 16'd50000;
  localparam logic [15:0] RST_CLEAR_EXTRA = 16'd10;

  // lcd command bytes and nibbles
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_HOME      = 8'h80;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0f;
  localparam logic [7:0] LCD_ROW1_BASE = 8'h80;
  localparam logic [7:0] LCD_ROW2_BASE = 8'hc0;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;

  // event step numbering
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] INIT_LAST      = 6'd32;
  localparam logic [STEP_W-1:0] BYTE_LAST      = 6'd3;
  localparam logic [STEP_W-1:0] WAKE_LAST      = 6'd6;
  localparam logic [STEP_W-1:0] NIB4_HIGH_STEP = 6'd7;
  localparam logic [STEP_W-1:0] NIB4_LAST      = 6'd8;
  localparam logic [STEP_W-1:0] INIT_BYTE_BASE = 6'd9;

  typedef struct packed {
    logic              load;
    logic              emit;
    logic [STEP_W-1:0] step;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic op_known;
    logic op_init;
  } status_t;

endpackage

// ===== hw/rtl/lcdns_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdns_ctrl
// request handshake, event step counter and output valid flag
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_sequencer_defines.svh"

module lcdns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lcdns_pkg::status_t  status,
  output lcdns_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state;
  logic                        state_next;
  logic [lcdns_pkg::STEP_W-1:0] step;
  logic [lcdns_pkg::STEP_W-1:0] step_next;
  logic                        is_init;
  logic                        is_init_next;
  logic                        out_valid_next;
  logic                        accept;
  logic                        space;
  logic                        at_last;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign space    = !out_valid || out_ready;
  assign at_last  = is_init ? (step == lcdns_pkg::INIT_LAST) : (step == lcdns_pkg::BYTE_LAST);

  always_comb begin
    state_next     = state;
    step_next      = step;
    is_init_next   = is_init;
    cmd.load       = 1'b0;
    cmd.emit       = 1'b0;
    cmd.step       = step;
    cmd.last       = at_last;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        cmd.load = accept;
        // unknown ops are taken and dropped
        if (accept && status.op_known) begin
          state_next   = ST_RUN;
          step_next    = '0;
          is_init_next = status.op_init;
        end
      end
      ST_RUN: begin
        if (space) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          if (at_last) begin
            state_next = ST_IDLE;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      is_init   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      is_init   <= is_init_next;
      out_valid <= out_valid_next;
    end
  end

  `LCDNS_ASSERT_NOW(a_step_bound, state == ST_RUN, step <= lcdns_pkg::INIT_LAST, "step past init run")
  `LCDNS_ASSERT_NOW(a_byte_bound, (state == ST_RUN) && !is_init, step <= lcdns_pkg::BYTE_LAST, "step past byte run")
  `LCDNS_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, state == ST_IDLE, "no return to idle after last event")
  `LCDNS_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !cmd.emit, "event overwrote a waiting transfer")

endmodule

// ===== hw/rtl/lcdns_dp.sv =====
// ----------------------------------------------------------------------------
// lcdns_dp
// timing registers, request capture, pin event generation and output register
// ----------------------------------------------------------------------------
module lcdns_dp #(
  parameter int COLUMNS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [2:0]          op,
  input  logic [7:0]          value,
  input  logic [1:0]          row,
  input  logic [7:0]          column,
  input  lcdns_pkg::cmd_t     cmd,
  output lcdns_pkg::status_t  status,
  output logic                reg_select,
  output logic                enable,
  output logic [3:0]          data_nibble,
  output logic [16:0]         hold_ticks,
  output logic                last
);

  // column offset by reciprocal multiply, exact for 8-bit values
  localparam int          RECIP  = (65536 + COLUMNS - 1) / COLUMNS;
  localparam logic [7:0]  COLS8  = 8'(COLUMNS);
  localparam logic [23:0] RECIP24 = 24'(RECIP);

  logic [15:0] enable_high_ticks;
  logic [15:0] settle_ticks;
  logic [15:0] wake_high_ticks;
  logic [15:0] wake_settle_ticks;
  logic [15:0] power_up_ticks;
  logic [15:0] clear_extra_ticks;

  logic [2:0]  op_q;
  logic [7:0]  value_q;
  logic        row_first;
  logic [7:0]  col_m1;
  logic [7:0]  quot;
  logic [3:0]  held_nibble;

  logic [7:0]  col_m1_in;
  logic [23:0] recip_prod;
  logic [7:0]  col_rem;
  logic [7:0]  cursor_addr;
  logic [16:0] clear_hold;

  logic [lcdns_pkg::STEP_W-1:0] init_rel;
  logic [2:0]  byte_idx;
  logic [1:0]  sub;
  logic [7:0]  byte_val;
  logic        byte_rs;
  logic        byte_clear;

  logic        ev_sel;
  logic        ev_en;
  logic [3:0]  ev_nib;
  logic [16:0] ev_hold;

  assign status.op_known = (op <= lcdns_pkg::OP_CLEAR);
  assign status.op_init  = (op == lcdns_pkg::OP_INIT);

  assign col_m1_in  = column - 8'd1;
  assign recip_prod = 24'(col_m1_in) * RECIP24;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_high_ticks <= lcdns_pkg::RST_ENABLE_HIGH;
      settle_ticks      <= lcdns_pkg::RST_SETTLE;
      wake_high_ticks   <= lcdns_pkg::RST_WAKE_HIGH;
      wake_settle_ticks <= lcdns_pkg::RST_WAKE_SETTLE;
      power_up_ticks    <= lcdns_pkg::RST_POWER_UP;
      clear_extra_ticks <= lcdns_pkg::RST_CLEAR_EXTRA;
    end else if (cfg_write) begin
      case (cfg_index)
        lcdns_pkg::REG_ENABLE_HIGH: enable_high_ticks <= cfg_data;
        lcdns_pkg::REG_SETTLE:      settle_ticks      <= cfg_data;
        lcdns_pkg::REG_WAKE_HIGH:   wake_high_ticks   <= cfg_data;
        lcdns_pkg::REG_WAKE_SETTLE: wake_settle_ticks <= cfg_data;
        lcdns_pkg::REG_POWER_UP:    power_up_ticks    <= cfg_data;
        lcdns_pkg::REG_CLEAR_EXTRA: clear_extra_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op;
      value_q   <= value;
      row_first <= (row == 2'd1);
      col_m1    <= col_m1_in;
      quot      <= recip_prod[23:16];
    end
  end

  assign col_rem     = col_m1 - 8'(quot * COLS8);
  assign cursor_addr = (row_first ? lcdns_pkg::LCD_ROW1_BASE : lcdns_pkg::LCD_ROW2_BASE) + col_rem;
  assign clear_hold  = 17'(settle_ticks) + 17'(clear_extra_ticks);

  assign init_rel = cmd.step - lcdns_pkg::INIT_BYTE_BASE;
  assign byte_idx = init_rel[4:2];

  // byte to send and its position within the four events of that byte
  always_comb begin
    byte_val   = lcdns_pkg::LCD_CLEAR;
    byte_rs    = 1'b0;
    byte_clear = 1'b0;
    sub        = cmd.step[1:0];
    if (op_q == lcdns_pkg::OP_INIT) begin
      sub = init_rel[1:0];
      case (byte_idx)
        3'd0: begin
          byte_val   = lcdns_pkg::LCD_CLEAR;
          byte_clear = 1'b1;
        end
        3'd1: byte_val = lcdns_pkg::LCD_FUNC_SET;
        3'd2: byte_val = lcdns_pkg::LCD_ENTRY;
        3'd3: byte_val = lcdns_pkg::LCD_HOME;
        3'd4: byte_val = lcdns_pkg::LCD_DISP_ON;
        default: begin
          byte_val   = lcdns_pkg::LCD_CLEAR;
          byte_clear = 1'b1;
        end
      endcase
    end else begin
      case (op_q)
        lcdns_pkg::OP_CMD:    byte_val = value_q;
        lcdns_pkg::OP_CHAR: begin
          byte_val = value_q;
          byte_rs  = 1'b1;
        end
        lcdns_pkg::OP_CURSOR: byte_val = cursor_addr;
        lcdns_pkg::OP_CLEAR:  byte_clear = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ev_sel  = byte_rs;
    ev_en   = !sub[0];
    ev_nib  = sub[1] ? byte_val[3:0] : byte_val[7:4];
    if (!sub[0]) begin
      ev_hold = 17'(enable_high_ticks);
    end else if (byte_clear && sub[1]) begin
      ev_hold = clear_hold;
    end else begin
      ev_hold = 17'(settle_ticks);
    end
    if (op_q == lcdns_pkg::OP_INIT) begin
      if (cmd.step == '0) begin
        // power-up wait keeps whatever the data lines last carried
        ev_sel  = 1'b0;
        ev_en   = 1'b0;
        ev_nib  = held_nibble;
        ev_hold = 17'(power_up_ticks);
      end else if (cmd.step <= lcdns_pkg::WAKE_LAST) begin
        ev_sel  = 1'b0;
        ev_en   = cmd.step[0];
        ev_nib  = lcdns_pkg::NIB_WAKE;
        ev_hold = cmd.step[0] ? 17'(wake_high_ticks) : 17'(wake_settle_ticks);
      end else if (cmd.step <= lcdns_pkg::NIB4_LAST) begin
        ev_sel  = 1'b0;
        ev_en   = (cmd.step == lcdns_pkg::NIB4_HIGH_STEP);
        ev_nib  = lcdns_pkg::NIB_4BIT;
        ev_hold = ev_en ? 17'(enable_high_ticks) : 17'(settle_ticks);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_nibble <= '0;
    end else if (cmd.emit) begin
      held_nibble <= ev_nib;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reg_select  <= ev_sel;
      enable      <= ev_en;
      data_nibble <= ev_nib;
      hold_ticks  <= ev_hold;
      last        <= cmd.last;
    end
  end

endmodule

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// character lcd controller for a 4-bit bus, emitting timed pin events
// ----------------------------------------------------------------------------
// requests come in on in_valid/in_ready with op, value, row and column;
// each one turns into a run of pin events on out_valid/out_ready, with last
// marking the final event of the run. ops 1 to 4 give four events, init gives
// thirty-three, unknown ops are taken and give nothing.
// one event is produced per cycle from the step counter of the controller
// while the receiver does not stall; an accepted request is registered into
// the run state, then each event into the output register. a new request
// is taken once the last event of the run sits in the output register.
// a stall on out_ready freezes the step counter and holds the waiting event.
// reset restores the timing registers to their defaults and clears the held
// data-line level; the cfg port may be written while no run is in progress.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
  parameter int COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  value,
  input  logic [1:0]  row,
  input  logic [7:0]  column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_select,
  output logic        enable,
  output logic [3:0]  data_nibble,
  output logic [16:0] hold_ticks,
  output logic        last,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lcdns_pkg::cmd_t    cmd;
  lcdns_pkg::status_t status;

  lcdns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcdns_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .value       (value),
    .row         (row),
    .column      (column),
    .cmd         (cmd),
    .status      (status),
    .reg_select  (reg_select),
    .enable      (enable),
    .data_nibble (data_nibble),
    .hold_ticks  (hold_ticks),
    .last        (last)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 4-bit character lcd sequencer: a directed
// table of requests, then random requests under several timing settings and
// handshake idling patterns. every pin event is checked against a predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int LINE_COLUMNS = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_PAD   = 8;
  localparam int HOLDOFF_LEN  = 400;
  localparam int GAP_MAX      = 40;

  // op codes with no defined behaviour, register indexes with no register
  localparam logic [2:0] OP_RSVD5    = 3'd5;
  localparam logic [2:0] OP_RSVD6    = 3'd6;
  localparam logic [2:0] OP_RSVD7    = 3'd7;
  localparam logic [2:0] REG_UNUSED6 = 3'd6;
  localparam logic [2:0] REG_UNUSED7 = 3'd7;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [16:0] hold;
    logic        last;
  } pin_event_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [1:0] row;
    logic [7:0] column;
    logic       typed;
    logic [7:0] bus_byte;
  } lcd_request_t;

  // bus_byte is the byte seen on the data lines, where it is obvious
  localparam int DIR_ROWS = 20;
  localparam lcd_request_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{lcdns_pkg::OP_INIT,   8'h00, 2'd0, 8'd0,   1'b0, 8'h00},
    '{lcdns_pkg::OP_CMD,    8'h00, 2'd3, 8'd255, 1'b1, 8'h00},
    '{lcdns_pkg::OP_CMD,    8'hff, 2'd0, 8'd0,   1'b1, 8'hff},
    '{lcdns_pkg::OP_CHAR,   8'h00, 2'd2, 8'd7,   1'b1, 8'h00},
    '{lcdns_pkg::OP_CHAR,   8'hff, 2'd1, 8'd1,   1'b1, 8'hff},
    '{lcdns_pkg::OP_CHAR,   8'ha5, 2'd0, 8'd0,   1'b1, 8'ha5},
    '{lcdns_pkg::OP_INIT,   8'hff, 2'd3, 8'd255, 1'b0, 8'h00},
    '{lcdns_pkg::OP_CURSOR, 8'hff, 2'd1, 8'd1,   1'b1, 8'h80},
    '{lcdns_pkg::OP_CURSOR, 8'h00, 2'd2, 8'd16,  1'b1, 8'hcf},
    '{lcdns_pkg::OP_CURSOR, 8'h00, 2'd1, 8'd0,   1'b1, 8'h8f},
    '{lcdns_pkg::OP_CURSOR, 8'h00, 2'd1, 8'd17,  1'b1, 8'h80},
    '{lcdns_pkg::OP_CURSOR, 8'h00, 2'd2, 8'd255, 1'b1, 8'hce},
    '{lcdns_pkg::OP_CURSOR, 8'h00, 2'd0, 8'd5,   1'b1, 8'hc4},
    '{lcdns_pkg::OP_CURSOR, 8'h00, 2'd3, 8'd8,   1'b1, 8'hc7},
    '{lcdns_pkg::OP_CLEAR,  8'h5a, 2'd3, 8'd200, 1'b1, 8'h01},
    '{lcdns_pkg::OP_CHAR,   8'h3c, 2'd0, 8'd0,   1'b1, 8'h3c},
    '{OP_RSVD5,             8'hff, 2'd3, 8'd255, 1'b0, 8'h00},
    '{OP_RSVD6,             8'h00, 2'd1, 8'd1,   1'b0, 8'h00},
    '{OP_RSVD7,             8'h81, 2'd2, 8'd128, 1'b0, 8'h00},
    '{lcdns_pkg::OP_INIT,   8'h00, 2'd0, 8'd0,   1'b0, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_op = lcdns_pkg::OP_CMD;
  logic [7:0]  req_value = 8'h00;
  logic [1:0]  req_row = 2'd1;
  logic [7:0]  req_column = 8'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        reg_select;
  logic        enable;
  logic [3:0]  data_nibble;
  logic [16:0] hold_ticks;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = lcdns_pkg::REG_ENABLE_HIGH;
  logic [15:0] cfg_data = 16'h0000;

  char_lcd_nibble_sequencer #(.COLUMNS(LINE_COLUMNS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (req_op),
    .value       (req_value),
    .row         (req_row),
    .column      (req_column),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .reg_select  (reg_select),
    .enable      (enable),
    .data_nibble (data_nibble),
    .hold_ticks  (hold_ticks),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state: timing registers and the data-line level left behind
  logic [15:0] t_en_high     = lcdns_pkg::RST_ENABLE_HIGH;
  logic [15:0] t_settle      = lcdns_pkg::RST_SETTLE;
  logic [15:0] t_wake_high   = lcdns_pkg::RST_WAKE_HIGH;
  logic [15:0] t_wake_settle = lcdns_pkg::RST_WAKE_SETTLE;
  logic [15:0] t_power_up    = lcdns_pkg::RST_POWER_UP;
  logic [15:0] t_clear_extra = lcdns_pkg::RST_CLEAR_EXTRA;
  logic [3:0]  held_nib      = 4'h0;

  pin_event_t pin_q[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         holdoff_req = 0;
  int         holdoff_seen = 0;
  int         holdoff_left = 0;

  function automatic void put_pin(logic rs, logic en, logic [3:0] nib, logic [16:0] hold);
    pin_event_t e;
    e.rs   = rs;
    e.en   = en;
    e.nib  = nib;
    e.hold = hold;
    e.last = 1'b0;
    pin_q.push_back(e);
    held_nib = nib;
  endfunction

  function automatic void strobe(logic rs, logic [3:0] nib, logic [16:0] hi, logic [16:0] lo);
    put_pin(rs, 1'b1, nib, hi);
    put_pin(rs, 1'b0, nib, lo);
  endfunction

  // high nibble first; a clear command stretches its final settle
  function automatic void put_lcd_byte(logic rs, logic [7:0] b, logic is_clear);
    logic [16:0] tail;
    tail = is_clear ? {1'b0, t_settle} + {1'b0, t_clear_extra} : {1'b0, t_settle};
    strobe(rs, b[7:4], t_en_high, t_settle);
    strobe(rs, b[3:0], t_en_high, tail);
  endfunction

  function automatic void expect_bus_byte(logic [2:0] o, logic [7:0] b);
    put_lcd_byte(o == lcdns_pkg::OP_CHAR, b, o == lcdns_pkg::OP_CLEAR);
    pin_q[$].last = 1'b1;
  endfunction

  function automatic void predict_lcd_run(logic [2:0] o, logic [7:0] v, logic [1:0] r,
                                          logic [7:0] c);
    int         n0;
    logic [7:0] offs;
    logic [7:0] addr;
    n0 = pin_q.size();
    case (o)
      lcdns_pkg::OP_INIT: begin
        put_pin(1'b0, 1'b0, held_nib, t_power_up);
        repeat (3) strobe(1'b0, lcdns_pkg::NIB_WAKE, t_wake_high, t_wake_settle);
        strobe(1'b0, lcdns_pkg::NIB_4BIT, t_en_high, t_settle);
        put_lcd_byte(1'b0, lcdns_pkg::LCD_CLEAR, 1'b1);
        put_lcd_byte(1'b0, lcdns_pkg::LCD_FUNC_SET, 1'b0);
        put_lcd_byte(1'b0, lcdns_pkg::LCD_ENTRY, 1'b0);
        put_lcd_byte(1'b0, lcdns_pkg::LCD_HOME, 1'b0);
        put_lcd_byte(1'b0, lcdns_pkg::LCD_DISP_ON, 1'b0);
        put_lcd_byte(1'b0, lcdns_pkg::LCD_CLEAR, 1'b1);
      end
      lcdns_pkg::OP_CMD:   put_lcd_byte(1'b0, v, 1'b0);
      lcdns_pkg::OP_CHAR:  put_lcd_byte(1'b1, v, 1'b0);
      lcdns_pkg::OP_CURSOR: begin
        // column is one-based; column zero wraps round to the end of the line
        offs = 8'(8'(c - 8'd1) % LINE_COLUMNS);
        addr = ((r == 2'd1) ? lcdns_pkg::LCD_ROW1_BASE : lcdns_pkg::LCD_ROW2_BASE) + offs;
        put_lcd_byte(1'b0, addr, 1'b0);
      end
      lcdns_pkg::OP_CLEAR: put_lcd_byte(1'b0, lcdns_pkg::LCD_CLEAR, 1'b1);
      default: ;
    endcase
    if (pin_q.size() > n0) pin_q[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result checking
  always @(posedge clk) begin
    pin_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pin_q.size() == 0) begin
        report_mismatch("event with nothing pending, nibble", data_nibble, 0);
      end else begin
        want = pin_q.pop_front();
        if (reg_select !== want.rs) report_mismatch("reg_select", reg_select, want.rs);
        if (enable !== want.en) report_mismatch("enable", enable, want.en);
        if (data_nibble !== want.nib) report_mismatch("data_nibble", data_nibble, want.nib);
        if (hold_ticks !== want.hold) report_mismatch("hold_ticks", hold_ticks, want.hold);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_LEN;
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("char_lcd_nibble_sequencer verification failed");
      $finish;
    end
  end

  task automatic send_request(lcd_request_t q);
    int gap;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_op     <= q.op;
    req_value  <= q.value;
    req_row    <= q.row;
    req_column <= q.column;
    do @(posedge clk); while (!in_ready);
    if (q.typed) expect_bus_byte(q.op, q.bus_byte);
    else predict_lcd_run(q.op, q.value, q.row, q.column);
  endtask

  function automatic lcd_request_t random_request();
    lcd_request_t q;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) q.op = lcdns_pkg::OP_INIT;
    else if (pick < 11) q.op = 3'($urandom_range(5, 7));
    else q.op = 3'($urandom_range(1, 4));
    q.value    = 8'($urandom_range(255));
    q.row      = 2'($urandom_range(3));
    q.column   = 8'($urandom_range(255));
    q.typed    = 1'b0;
    q.bus_byte = 8'h00;
    return q;
  endfunction

  // wait for every pending event, then let any ignored request finish
  task automatic wait_runs_done();
    in_valid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      lcdns_pkg::REG_ENABLE_HIGH: t_en_high     = d;
      lcdns_pkg::REG_SETTLE:      t_settle      = d;
      lcdns_pkg::REG_WAKE_HIGH:   t_wake_high   = d;
      lcdns_pkg::REG_WAKE_SETTLE: t_wake_settle = d;
      lcdns_pkg::REG_POWER_UP:    t_power_up    = d;
      lcdns_pkg::REG_CLEAR_EXTRA: t_clear_extra = d;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [15:0] eh, logic [15:0] st, logic [15:0] wh,
                            logic [15:0] ws, logic [15:0] pu, logic [15:0] ce);
    write_reg(lcdns_pkg::REG_ENABLE_HIGH, eh);
    write_reg(lcdns_pkg::REG_SETTLE, st);
    write_reg(lcdns_pkg::REG_WAKE_HIGH, wh);
    write_reg(lcdns_pkg::REG_WAKE_SETTLE, ws);
    write_reg(lcdns_pkg::REG_POWER_UP, pu);
    write_reg(lcdns_pkg::REG_CLEAR_EXTRA, ce);
    cfg_write <= 1'b0;
  endtask

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      send_request(random_request());
      // now and then the sender waits for the display to catch up
      if (i % 40 == 39) wait_runs_done();
    end
    wait_runs_done();
  endtask

  function automatic logic [15:0] rand_tick();
    return 16'($urandom_range(1, 65535));
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset timing, no idling
    for (int i = 0; i < DIR_ROWS; i++) send_request(DIR_TAB[i]);
    wait_runs_done();

    // shortest legal holds, sender mostly idle
    set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
    idle_pct = 78;
    random_burst(110);

    // longest holds, clear transfer hold needs all of its 17 bits
    set_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    idle_pct  = 0;
    stall_pct = 78;
    random_burst(110);

    // random timing, writes to missing registers must change nothing
    set_timing(rand_tick(), rand_tick(), rand_tick(), rand_tick(), rand_tick(), rand_tick());
    write_reg(REG_UNUSED6, 16'hffff);
    write_reg(REG_UNUSED7, 16'h0000);
    cfg_write <= 1'b0;
    idle_pct  = 6;
    stall_pct = 6;
    random_burst(110);

    // zero holds pass through; receiver holds off so the input backs up
    set_timing(16'd0, 16'd0, rand_tick(), 16'd0, 16'hffff, rand_tick());
    idle_pct  = 0;
    stall_pct = 0;
    holdoff_req++;
    for (int i = 0; i < 30; i++) send_request(random_request());
    random_burst(70);

    if (mismatches == 0) begin
      $display("char_lcd_nibble_sequencer verification clean");
    end else begin
      $display("char_lcd_nibble_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_ctrl.sv
hw/rtl/lcdns_dp.sv
hw/rtl/char_lcd_nibble_sequencer.sv
tb/tb.sv
